[rtl/cmts_pkg.sv]
// Shared types, token and character codes, and keyword table for the C-minus token scanner.
package cmts_pkg;

    localparam int KW_COUNT    = 6;
    localparam int KW_MAX      = 6;
    localparam int RBUF_DEPTH  = 4;
    localparam int RBUF_PTR_W  = 2;
    localparam int RBUF_CNT_W  = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [2:0]  error_kind;
        logic [15:0] line_number;
        logic [19:0] start_offset;
        logic [7:0]  text_length;
        logic        last_result;
    } res_beat_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_beat_t  beat0;
        res_beat_t  beat1;
    } res_push_t;

    typedef enum logic [3:0] {
        ST_START, ST_NUM, ST_ID, ST_EQ, ST_LT, ST_GT, ST_SLASH, ST_BANG,
        ST_COMMENT, ST_STAR, ST_SKIP, ST_DOLLAR
    } scan_state_t;

    localparam logic IN_CHAR = 1'b0;
    localparam logic IN_EOF  = 1'b1;

    localparam logic [4:0] TK_ELSE      = 5'd0;
    localparam logic [4:0] TK_IF        = 5'd1;
    localparam logic [4:0] TK_INT       = 5'd2;
    localparam logic [4:0] TK_RETURN    = 5'd3;
    localparam logic [4:0] TK_VOID      = 5'd4;
    localparam logic [4:0] TK_WHILE     = 5'd5;
    localparam logic [4:0] TK_ADD       = 5'd6;
    localparam logic [4:0] TK_SUB       = 5'd7;
    localparam logic [4:0] TK_TIMES     = 5'd8;
    localparam logic [4:0] TK_DIV       = 5'd9;
    localparam logic [4:0] TK_LT        = 5'd10;
    localparam logic [4:0] TK_LTE       = 5'd11;
    localparam logic [4:0] TK_GT        = 5'd12;
    localparam logic [4:0] TK_GTE       = 5'd13;
    localparam logic [4:0] TK_EQ        = 5'd14;
    localparam logic [4:0] TK_NOT_EQ    = 5'd15;
    localparam logic [4:0] TK_ASSIGN    = 5'd16;
    localparam logic [4:0] TK_SEMI      = 5'd17;
    localparam logic [4:0] TK_COMMA     = 5'd18;
    localparam logic [4:0] TK_O_PAREN   = 5'd19;
    localparam logic [4:0] TK_C_PAREN   = 5'd20;
    localparam logic [4:0] TK_O_BRACKET = 5'd21;
    localparam logic [4:0] TK_C_BRACKET = 5'd22;
    localparam logic [4:0] TK_O_BRACE   = 5'd23;
    localparam logic [4:0] TK_C_BRACE   = 5'd24;
    localparam logic [4:0] TK_ID        = 5'd25;
    localparam logic [4:0] TK_NUM       = 5'd26;
    localparam logic [4:0] TK_ENDFILE   = 5'd27;
    localparam logic [4:0] TK_ERROR     = 5'd28;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NUM     = 3'd1;
    localparam logic [2:0] ERR_ID      = 3'd2;
    localparam logic [2:0] ERR_STRAY   = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN = 3'd4;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_O_PAREN  = 8'h28;
    localparam logic [7:0] CH_C_PAREN  = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_O_BRACK  = 8'h5B;
    localparam logic [7:0] CH_C_BRACK  = 8'h5D;
    localparam logic [7:0] CH_O_BRACE  = 8'h7B;
    localparam logic [7:0] CH_C_BRACE  = 8'h7D;

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd4, 8'd2, 8'd3, 8'd6, 8'd4, 8'd5};

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };

    function automatic logic [4:0] id_token(input logic [KW_MAX-1:0][7:0] kw,
                                            input logic [7:0] len);
        logic [4:0] kind;
        logic       hit;
        kind = TK_ID;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX; i++) begin
                if ((8'(i) < KW_LEN[k]) && (kw[i] != KW_TEXT[k][i])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic res_beat_t make_beat(input logic [4:0] kind, input logic [2:0] err,
                                            input logic [15:0] line,
                                            input logic [19:0] start,
                                            input logic [7:0] len);
        res_beat_t b;
        b.token_kind   = kind;
        b.error_kind   = err;
        b.line_number  = line;
        b.start_offset = start;
        b.text_length  = len;
        b.last_result  = 1'b0;
        return b;
    endfunction

endpackage

[rtl/cmts_scan.sv]
// Scanner state, counters, keyword buffer and single-pass token decision logic.
module cmts_scan #(
    parameter int OFFSET_BITS   = 20,
    parameter int LINE_BITS     = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  cmts_pkg::in_beat_t item,
    output cmts_pkg::res_push_t push
);
    import cmts_pkg::*;

    scan_state_t                   state_reg, state_next;
    logic [LINE_BITS-1:0]          line_count_reg;
    logic [OFFSET_BITS-1:0]        char_offset_reg;
    logic [OFFSET_BITS-1:0]        token_start_reg;
    logic [7:0]                    token_len_reg;
    logic [KEYWORD_CHARS-1:0][7:0] kw_buf_reg;

    logic [7:0]  c;
    logic        is_dig, is_let;
    logic [15:0] line_out;
    logic [19:0] tok_start, cur_off;
    logic [7:0]  len_grown;

    logic        fl_v;
    res_beat_t   fl_beat;
    logic        st_v, st_begin, st_inc;
    res_beat_t   st_beat;
    scan_state_t st_state;

    logic        r0_v, r1_v;
    res_beat_t   r0, r1;
    logic        do_begin, do_grow, do_line_inc, do_off_inc;
    logic        same, other;
    logic [4:0]  pair_kind;

    assign c         = item.char_code;
    assign is_dig    = (c >= "0") && (c <= "9");
    assign is_let    = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign line_out  = 16'(line_count_reg);
    assign tok_start = 20'(token_start_reg);
    assign cur_off   = 20'(char_offset_reg);
    assign len_grown = (token_len_reg == 8'hFF) ? token_len_reg : token_len_reg + 8'd1;

    // pending token in the current state
    always_comb begin
        fl_v    = 1'b1;
        fl_beat = make_beat(TK_ERROR, ERR_NONE, line_out, tok_start, 8'd1);
        case (state_reg)
            ST_NUM:   fl_beat = make_beat(TK_NUM, ERR_NONE, line_out, tok_start, token_len_reg);
            ST_ID:    fl_beat = make_beat(id_token(kw_buf_reg[KW_MAX-1:0], token_len_reg),
                                          ERR_NONE, line_out, tok_start, token_len_reg);
            ST_EQ:    fl_beat.token_kind = TK_ASSIGN;
            ST_LT:    fl_beat.token_kind = TK_LT;
            ST_GT:    fl_beat.token_kind = TK_GT;
            ST_SLASH: fl_beat.token_kind = TK_DIV;
            ST_BANG:  fl_beat.error_kind = ERR_STRAY;
            default:  fl_v = 1'b0;
        endcase
    end

    // character seen from the start state
    always_comb begin
        st_v     = 1'b0;
        st_begin = 1'b0;
        st_inc   = 1'b0;
        st_state = ST_START;
        st_beat  = make_beat(TK_ERROR, ERR_NONE, line_out, cur_off, 8'd1);
        if (is_dig) begin
            st_begin = 1'b1;
            st_state = ST_NUM;
        end else if (is_let) begin
            st_begin = 1'b1;
            st_state = ST_ID;
        end else begin
            st_v = 1'b1;
            case (c)
                CH_EQ:      begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_EQ;     end
                CH_LT:      begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_LT;     end
                CH_GT:      begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_GT;     end
                CH_SLASH:   begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_SLASH;  end
                CH_BANG:    begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_BANG;   end
                CH_DOLLAR:  begin st_v = 1'b0; st_begin = 1'b1; st_state = ST_DOLLAR; end
                CH_SPACE,
                CH_TAB:     st_v = 1'b0;
                CH_NL:      begin st_v = 1'b0; st_inc = 1'b1; end
                CH_STAR:    st_beat.token_kind = TK_TIMES;
                CH_PLUS:    st_beat.token_kind = TK_ADD;
                CH_MINUS:   st_beat.token_kind = TK_SUB;
                CH_O_BRACK: st_beat.token_kind = TK_O_BRACKET;
                CH_C_BRACK: st_beat.token_kind = TK_C_BRACKET;
                CH_O_PAREN: st_beat.token_kind = TK_O_PAREN;
                CH_C_PAREN: st_beat.token_kind = TK_C_PAREN;
                CH_O_BRACE: st_beat.token_kind = TK_O_BRACE;
                CH_C_BRACE: st_beat.token_kind = TK_C_BRACE;
                CH_COMMA:   st_beat.token_kind = TK_COMMA;
                CH_SEMI:    st_beat.token_kind = TK_SEMI;
                default:    st_beat.error_kind = ERR_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        r0_v        = 1'b0;
        r1_v        = 1'b0;
        r0          = fl_beat;
        r1          = st_beat;
        do_begin    = 1'b0;
        do_grow     = 1'b0;
        do_line_inc = 1'b0;
        do_off_inc  = 1'b0;
        same        = (state_reg == ST_NUM) ? is_dig : is_let;
        other       = (state_reg == ST_NUM) ? is_let : is_dig;
        case (state_reg)
            ST_LT:   pair_kind = TK_LTE;
            ST_GT:   pair_kind = TK_GTE;
            ST_BANG: pair_kind = TK_NOT_EQ;
            default: pair_kind = TK_EQ;
        endcase
        if (item_valid) begin
            if (item.kind == IN_EOF) begin
                r0_v       = fl_v;
                r1_v       = 1'b1;
                r1         = make_beat(TK_ENDFILE, ERR_NONE, line_out, cur_off, 8'd0);
                state_next = ST_START;
            end else begin
                do_off_inc = 1'b1;
                case (state_reg)
                    ST_NUM, ST_ID: begin
                        if (same) begin
                            do_grow = 1'b1;
                        end else if (other) begin
                            do_grow    = 1'b1;
                            r0_v       = 1'b1;
                            r0         = make_beat(TK_ERROR,
                                                   (state_reg == ST_NUM) ? ERR_NUM : ERR_ID,
                                                   line_out, tok_start, len_grown);
                            state_next = ST_SKIP;
                        end else begin
                            r0_v        = 1'b1;
                            r1_v        = st_v;
                            state_next  = st_state;
                            do_begin    = st_begin;
                            do_line_inc = st_inc;
                        end
                    end
                    ST_EQ, ST_LT, ST_GT, ST_BANG: begin
                        if (c == CH_EQ) begin
                            r0_v       = 1'b1;
                            r0         = make_beat(pair_kind, ERR_NONE, line_out, tok_start,
                                                   8'd2);
                            state_next = ST_START;
                        end else begin
                            r0_v        = 1'b1;
                            r1_v        = st_v;
                            state_next  = st_state;
                            do_begin    = st_begin;
                            do_line_inc = st_inc;
                        end
                    end
                    ST_SLASH: begin
                        if (c == CH_STAR) begin
                            state_next = ST_COMMENT;
                        end else begin
                            r0_v        = 1'b1;
                            r1_v        = st_v;
                            state_next  = st_state;
                            do_begin    = st_begin;
                            do_line_inc = st_inc;
                        end
                    end
                    ST_COMMENT: begin
                        if (c == CH_STAR) begin
                            state_next = ST_STAR;
                        end else if (c == CH_NL) begin
                            do_line_inc = 1'b1;
                        end
                    end
                    ST_STAR: begin
                        if (c == CH_SLASH) begin
                            state_next = ST_START;
                        end else if (c != CH_STAR) begin
                            do_line_inc = (c == CH_NL);
                            state_next  = ST_COMMENT;
                        end
                    end
                    ST_SKIP: begin
                        if (!is_dig && !is_let) begin
                            r1_v        = st_v;
                            state_next  = st_state;
                            do_begin    = st_begin;
                            do_line_inc = st_inc;
                        end
                    end
                    ST_DOLLAR: begin
                        r0_v        = 1'b1;
                        r0          = make_beat(TK_ERROR, ERR_STRAY, line_out, tok_start,
                                                8'd1);
                        r1_v        = st_v;
                        state_next  = st_state;
                        do_begin    = st_begin;
                        do_line_inc = st_inc;
                    end
                    default: begin
                        r1_v        = st_v;
                        state_next  = st_state;
                        do_begin    = st_begin;
                        do_line_inc = st_inc;
                    end
                endcase
            end
        end

        // pack results front first, flag the last
        push.beat1 = r1;
        push.beat1.last_result = 1'b1;
        if (r0_v && r1_v) begin
            push.cnt   = 2'd2;
            push.beat0 = r0;
        end else if (r0_v) begin
            push.cnt   = 2'd1;
            push.beat0 = r0;
            push.beat0.last_result = 1'b1;
        end else if (r1_v) begin
            push.cnt   = 2'd1;
            push.beat0 = r1;
            push.beat0.last_result = 1'b1;
        end else begin
            push.cnt   = 2'd0;
            push.beat0 = r0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_START;
            line_count_reg  <= LINE_BITS'(1);
            char_offset_reg <= '0;
            token_start_reg <= '0;
            token_len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (do_line_inc && (line_count_reg != '1)) begin
                line_count_reg <= line_count_reg + LINE_BITS'(1);
            end
            if (do_off_inc) begin
                char_offset_reg <= char_offset_reg + OFFSET_BITS'(1);
            end
            if (do_begin) begin
                token_start_reg <= char_offset_reg;
                token_len_reg   <= 8'd1;
            end else if (do_grow) begin
                token_len_reg <= len_grown;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (do_begin && (i == 0)) begin
                kw_buf_reg[i] <= c;
            end else if (do_grow && (token_len_reg == 8'(i))) begin
                kw_buf_reg[i] <= c;
            end
        end
    end

endmodule

[rtl/cmts_rbuf.sv]
// Four-entry result queue taking up to two results per cycle and giving one per beat.
module cmts_rbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmts_pkg::res_push_t push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output cmts_pkg::res_beat_t m_data
);
    import cmts_pkg::*;

    res_beat_t               mem [RBUF_DEPTH];
    logic [RBUF_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_nx1;
    logic [RBUF_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    assign pop        = m_valid && m_ready;
    assign room       = (count_reg <= RBUF_CNT_W'(RBUF_DEPTH - 2));
    assign m_valid    = (count_reg != '0);
    assign m_data     = mem[rd_ptr_reg];
    assign wr_ptr_nx1 = wr_ptr_reg + RBUF_PTR_W'(1);
    assign count_next = count_reg + RBUF_CNT_W'(push.cnt) - RBUF_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RBUF_PTR_W'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + RBUF_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.beat0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_nx1] <= push.beat1;
        end
    end

endmodule

[rtl/c_minus_token_scanner_core.sv]
// Top level of the C-minus token scanner: input register, scanner and result queue.
//
// Usage: source bytes go in on the s_ channel, one character or end-of-input
// marker per beat (s_data.kind). Tokens come out on the m_ channel, one per
// beat, each with kind, error kind, line, start offset and length; last_result
// marks the final token caused by an input beat.
// A token appears on m_valid after the input beat that completes it passes the
// input register and the scan step writes the token into the result queue.
// Throughput: one input beat per cycle while the receiver keeps up. A beat
// may yield two tokens; the queue output gives one token per cycle, so input
// then slows to the rate at which tokens drain. s_ready drops when the
// four-entry queue holds more than two tokens and the input register is full.
// Reset (aresetn low, synchronous) clears the scan state to start, line to 1,
// offset and token counters to zero and empties the queue.
// When the receiver stalls, m_data holds and the queue fills; once it holds more
// than two tokens the input side stalls as well, and nothing is lost.
module c_minus_token_scanner_core #(
    parameter int OFFSET_BITS   = 20,
    parameter int LINE_BITS     = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cmts_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cmts_pkg::res_beat_t m_data
);
    import cmts_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      room;
    logic      consume;
    res_push_t push;

    assign consume = in_valid_reg && room;
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    cmts_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (consume),
        .item       (in_data_reg),
        .push       (push)
    );

    cmts_rbuf u_rbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/cmts_checker.sv]
// Port-level checks for the C-minus token scanner, bound to the top level.
module cmts_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input cmts_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input cmts_pkg::res_beat_t m_data
);
    import cmts_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.token_kind == TK_ERROR) == (m_data.error_kind != ERR_NONE)))
        else $error("error kind inconsistent with token kind");

    a_endfile: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.token_kind == TK_ENDFILE)
            |-> (m_data.text_length == 8'd0) && m_data.last_result)
        else $error("end-of-file token malformed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while stalled");

endmodule

bind c_minus_token_scanner_core cmts_checker u_cmts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[bench/c_minus_token_scanner_core_tb.sv]
// Self-checking testbench for the C-minus token scanner: directed rows and random source.
`timescale 1ns / 100ps

module c_minus_token_scanner_core_tb;
    import cmts_pkg::*;

    localparam int          STALL_LIMIT = 1000;
    localparam int          RAND_ITEMS  = 1850;
    localparam int          WORD_BYTES  = 6;
    localparam int          DIR_COUNT   = 26;
    localparam logic [15:0] LINE_TOP    = 16'hFFFF;

    typedef struct packed {
        logic      kind;
        logic [7:0] ch;
        logic      typed;
        res_beat_t want;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    res_beat_t m_data;

    // scanner shadow
    scan_state_t sc_state;
    logic [15:0] sc_line;
    logic [19:0] sc_offset;
    logic [19:0] sc_tok_start;
    logic [7:0]  sc_tok_len;
    logic [7:0]  sc_kw [WORD_BYTES];

    res_beat_t token_q [$];
    res_beat_t step_toks [$];
    in_beat_t  src_q [$];
    dir_row_t  dir_rows [DIR_COUNT];

    string      word_text [6] = '{"else", "if", "int", "return", "void", "while"};
    logic [4:0] word_code [6] = '{TK_ELSE, TK_IF, TK_INT, TK_RETURN, TK_VOID, TK_WHILE};
    string      pair_text [4] = '{"==", "<=", ">=", "!="};
    string      sym_chars     = "+-*/<>=!;,()[]{}";
    string      body_chars    = "*/\n a";

    int bad_beats  = 0;
    int idle_count = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    int rx_hold    = 0;

    c_minus_token_scanner_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) calm = $urandom_range(40, 200);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- scanner shadow ----------------
    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void clear_scan();
        sc_state     = ST_START;
        sc_line      = 16'd1;
        sc_offset    = '0;
        sc_tok_start = '0;
        sc_tok_len   = '0;
        for (int i = 0; i < WORD_BYTES; i++) sc_kw[i] = '0;
    endfunction

    function automatic void note_tok(logic [4:0] kind, logic [2:0] err, logic [19:0] start,
                                     logic [7:0] len);
        res_beat_t t;
        t.token_kind   = kind;
        t.error_kind   = err;
        t.line_number  = sc_line;
        t.start_offset = start;
        t.text_length  = len;
        t.last_result  = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void line_bump();
        if (sc_line != LINE_TOP) sc_line++;
    endfunction

    function automatic void open_tok(logic [7:0] c);
        sc_tok_start = sc_offset;
        sc_tok_len   = 8'd1;
        sc_kw[0]     = c;
    endfunction

    function automatic void grow_tok(logic [7:0] c);
        if (sc_tok_len < WORD_BYTES) sc_kw[sc_tok_len] = c;
        if (sc_tok_len != 8'hFF) sc_tok_len++;
    endfunction

    function automatic logic [4:0] word_kind();
        logic hit;
        for (int k = 0; k < 6; k++) begin
            hit = (sc_tok_len == word_text[k].len());
            for (int i = 0; hit && i < word_text[k].len(); i++) begin
                if (sc_kw[i] != word_text[k][i]) hit = 1'b0;
            end
            if (hit) return word_code[k];
        end
        return TK_ID;
    endfunction

    function automatic void flush_tok();
        case (sc_state)
            ST_NUM:   note_tok(TK_NUM, ERR_NONE, sc_tok_start, sc_tok_len);
            ST_ID:    note_tok(word_kind(), ERR_NONE, sc_tok_start, sc_tok_len);
            ST_EQ:    note_tok(TK_ASSIGN, ERR_NONE, sc_tok_start, 8'd1);
            ST_LT:    note_tok(TK_LT, ERR_NONE, sc_tok_start, 8'd1);
            ST_GT:    note_tok(TK_GT, ERR_NONE, sc_tok_start, 8'd1);
            ST_SLASH: note_tok(TK_DIV, ERR_NONE, sc_tok_start, 8'd1);
            ST_BANG:  note_tok(TK_ERROR, ERR_STRAY, sc_tok_start, 8'd1);
            default: ;
        endcase
        sc_state = ST_START;
    endfunction

    function automatic void scan_fresh(logic [7:0] c);
        logic [4:0] k;
        logic       hit;
        sc_state = ST_START;
        hit = 1'b1;
        k = TK_ERROR;
        if (is_digit(c)) begin
            open_tok(c);
            sc_state = ST_NUM;
            return;
        end
        if (is_letter(c)) begin
            open_tok(c);
            sc_state = ST_ID;
            return;
        end
        case (c)
            CH_EQ, CH_LT, CH_GT, CH_SLASH, CH_BANG, CH_DOLLAR: begin
                open_tok(c);
                case (c)
                    CH_EQ:    sc_state = ST_EQ;
                    CH_LT:    sc_state = ST_LT;
                    CH_GT:    sc_state = ST_GT;
                    CH_SLASH: sc_state = ST_SLASH;
                    CH_BANG:  sc_state = ST_BANG;
                    default:  sc_state = ST_DOLLAR;
                endcase
                hit = 1'b0;
            end
            CH_SPACE, CH_TAB: hit = 1'b0;
            CH_NL: begin
                line_bump();
                hit = 1'b0;
            end
            CH_STAR:    k = TK_TIMES;
            CH_PLUS:    k = TK_ADD;
            CH_MINUS:   k = TK_SUB;
            CH_O_BRACK: k = TK_O_BRACKET;
            CH_C_BRACK: k = TK_C_BRACKET;
            CH_O_PAREN: k = TK_O_PAREN;
            CH_C_PAREN: k = TK_C_PAREN;
            CH_O_BRACE: k = TK_O_BRACE;
            CH_C_BRACE: k = TK_C_BRACE;
            CH_COMMA:   k = TK_COMMA;
            CH_SEMI:    k = TK_SEMI;
            default:    k = TK_ERROR;
        endcase
        if (hit) note_tok(k, (k == TK_ERROR) ? ERR_UNKNOWN : ERR_NONE, sc_offset, 8'd1);
    endfunction

    function automatic void pair_or_flush(logic [7:0] c, logic [4:0] pair);
        if (c == CH_EQ) begin
            sc_state = ST_START;
            note_tok(pair, ERR_NONE, sc_tok_start, 8'd2);
        end else begin
            flush_tok();
            scan_fresh(c);
        end
    endfunction

    // tokens caused by one input beat land in step_toks
    function automatic void scan_beat(in_beat_t b);
        logic       same, other;
        logic [2:0] err;
        logic [7:0] c;
        res_beat_t  t;
        step_toks.delete();
        c = b.char_code;
        if (b.kind == IN_EOF) begin
            flush_tok();
            note_tok(TK_ENDFILE, ERR_NONE, sc_offset, 8'd0);
        end else begin
            case (sc_state)
                ST_NUM, ST_ID: begin
                    same  = (sc_state == ST_NUM) ? is_digit(c) : is_letter(c);
                    other = (sc_state == ST_NUM) ? is_letter(c) : is_digit(c);
                    err   = (sc_state == ST_NUM) ? ERR_NUM : ERR_ID;
                    if (same) begin
                        grow_tok(c);
                    end else if (other) begin
                        grow_tok(c);
                        note_tok(TK_ERROR, err, sc_tok_start, sc_tok_len);
                        sc_state = ST_SKIP;
                    end else begin
                        flush_tok();
                        scan_fresh(c);
                    end
                end
                ST_EQ:   pair_or_flush(c, TK_EQ);
                ST_LT:   pair_or_flush(c, TK_LTE);
                ST_GT:   pair_or_flush(c, TK_GTE);
                ST_BANG: pair_or_flush(c, TK_NOT_EQ);
                ST_SLASH: begin
                    if (c == CH_STAR) begin
                        sc_state = ST_COMMENT;
                    end else begin
                        flush_tok();
                        scan_fresh(c);
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_STAR) sc_state = ST_STAR;
                    else if (c == CH_NL) line_bump();
                end
                ST_STAR: begin
                    if (c == CH_SLASH) begin
                        sc_state = ST_START;
                    end else if (c != CH_STAR) begin
                        if (c == CH_NL) line_bump();
                        sc_state = ST_COMMENT;
                    end
                end
                ST_SKIP: begin
                    if (!is_digit(c) && !is_letter(c)) scan_fresh(c);
                end
                ST_DOLLAR: begin
                    note_tok(TK_ERROR, ERR_STRAY, sc_tok_start, 8'd1);
                    scan_fresh(c);
                end
                default: scan_fresh(c);
            endcase
            sc_offset++;
        end
        if (step_toks.size() != 0) begin
            t = step_toks.pop_back();
            t.last_result = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // ---------------- source text generation ----------------
    function automatic void add_ch(logic [7:0] c);
        in_beat_t b;
        b.kind      = IN_CHAR;
        b.char_code = c;
        src_q.push_back(b);
    endfunction

    function automatic void add_eof();
        in_beat_t b;
        b.kind      = IN_EOF;
        b.char_code = 8'($urandom_range(0, 255));
        src_q.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_ch(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return CH_TAB;
            1:       return CH_NL;
            default: return CH_SPACE;
        endcase
    endfunction

    // runs of 250 to 300 characters, mostly long enough to saturate the length count
    function automatic void add_long();
        int n;
        n = $urandom_range(250, 300);
        if ($urandom_range(0, 1)) begin
            repeat (n) add_ch(rand_letter());
        end else begin
            repeat (n) add_ch(rand_digit());
        end
        add_ch(CH_SPACE);
    endfunction

    function automatic void add_fragment();
        int    pick, n;
        string s;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            s = word_text[$urandom_range(0, 5)];
            case ($urandom_range(0, 9))
                0: begin
                    add_text(s);
                    add_ch(rand_letter());
                end
                1: add_text(s.substr(0, s.len() - 2));
                2: begin
                    add_ch(s[0] - 8'd32);
                    add_text(s.substr(1, s.len() - 1));
                end
                default: add_text(s);
            endcase
        end else if (pick < 30) begin
            n = $urandom_range(1, 8);
            repeat (n) add_ch(rand_letter());
        end else if (pick < 40) begin
            n = $urandom_range(1, 6);
            repeat (n) add_ch(rand_digit());
        end else if (pick < 58) begin
            if ($urandom_range(0, 5) == 0) add_text(pair_text[$urandom_range(0, 3)]);
            else add_ch(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
        end else if (pick < 64) begin
            add_text("/*");
            n = $urandom_range(0, 10);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) add_ch(8'($urandom_range(0, 255)));
                else add_ch(body_chars[$urandom_range(0, body_chars.len() - 1)]);
            end
            case ($urandom_range(0, 3))
                0:       add_text("**/");
                1:       add_eof();
                default: add_text("*/");
            endcase
        end else if (pick < 70) begin
            n = $urandom_range(1, 3);
            if ($urandom_range(0, 1)) begin
                repeat (n) add_ch(rand_digit());
                add_ch(rand_letter());
            end else begin
                repeat (n) add_ch(rand_letter());
                add_ch(rand_digit());
            end
            n = $urandom_range(0, 3);
            repeat (n) add_ch($urandom_range(0, 1) ? rand_letter() : rand_digit());
        end else if (pick < 75) begin
            add_ch($urandom_range(0, 1) ? CH_DOLLAR : CH_BANG);
            if ($urandom_range(0, 3) == 0) add_eof();
        end else if (pick < 84) begin
            add_ch(8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            add_eof();
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) add_ch(rand_space());
        end
        if ($urandom_range(0, 9) < 6) add_ch(rand_space());
        if ($urandom_range(0, 199) == 0) add_long();
    endfunction

    // ---------------- checking ----------------
    function automatic void check_token(res_beat_t got);
        res_beat_t want;
        if (token_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("unexpected token beat: kind %0d err %0d line %0d start %0h len %0d",
                         got.token_kind, got.error_kind, got.line_number, got.start_offset,
                         got.text_length);
            return;
        end
        want = token_q.pop_front();
        if (got.token_kind !== want.token_kind || got.error_kind !== want.error_kind ||
            got.line_number !== want.line_number || got.start_offset !== want.start_offset ||
            got.text_length !== want.text_length || got.last_result !== want.last_result) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("token mismatch: exp %0d/%0d/%0d/%0h/%0d/%0b got %0d/%0d/%0d/%0h/%0d/%0b",
                         want.token_kind, want.error_kind, want.line_number, want.start_offset,
                         want.text_length, want.last_result, got.token_kind, got.error_kind,
                         got.line_number, got.start_offset, got.text_length, got.last_result);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_token(m_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_hold <= pick_gap(rx_calm);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------- driving ----------------
    task automatic offer(in_beat_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic feed(in_beat_t b, int gap);
        offer(b);
        scan_beat(b);
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        idle(gap);
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        do @(posedge aclk); while (token_q.size() != 0);
    endtask

    function automatic res_beat_t tok(logic [4:0] kind, logic [2:0] err, logic [15:0] line,
                                      logic [19:0] start, logic [7:0] len);
        res_beat_t t;
        t.token_kind   = kind;
        t.error_kind   = err;
        t.line_number  = line;
        t.start_offset = start;
        t.text_length  = len;
        t.last_result  = 1'b1;
        return t;
    endfunction

    function automatic dir_row_t row(logic kind, logic [7:0] ch, logic typed, res_beat_t want);
        dir_row_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    initial begin
        in_beat_t b;
        clear_scan();
        dir_rows = '{
            row(IN_CHAR, "@",       1'b1, tok(TK_ERROR, ERR_UNKNOWN, 16'd1, 20'd0, 8'd1)),
            row(IN_CHAR, 8'hFF,     1'b1, tok(TK_ERROR, ERR_UNKNOWN, 16'd1, 20'd1, 8'd1)),
            row(IN_CHAR, 8'h00,     1'b1, tok(TK_ERROR, ERR_UNKNOWN, 16'd1, 20'd2, 8'd1)),
            row(IN_CHAR, CH_DOLLAR, 1'b0, '0),
            row(IN_CHAR, CH_BANG,   1'b1, tok(TK_ERROR, ERR_STRAY, 16'd1, 20'd3, 8'd1)),
            row(IN_CHAR, "x",       1'b1, tok(TK_ERROR, ERR_STRAY, 16'd1, 20'd4, 8'd1)),
            row(IN_CHAR, "1",       1'b1, tok(TK_ERROR, ERR_ID, 16'd1, 20'd5, 8'd2)),
            row(IN_CHAR, "a",       1'b0, '0),
            row(IN_CHAR, CH_SPACE,  1'b0, '0),
            row(IN_CHAR, "9",       1'b0, '0),
            row(IN_CHAR, "q",       1'b1, tok(TK_ERROR, ERR_NUM, 16'd1, 20'd9, 8'd2)),
            row(IN_CHAR, CH_NL,     1'b0, '0),
            row(IN_CHAR, CH_EQ,     1'b0, '0),
            row(IN_CHAR, CH_EQ,     1'b0, '0),
            row(IN_CHAR, CH_BANG,   1'b0, '0),
            row(IN_CHAR, CH_EQ,     1'b0, '0),
            row(IN_CHAR, CH_LT,     1'b0, '0),
            row(IN_CHAR, CH_GT,     1'b0, '0),
            row(IN_CHAR, CH_SLASH,  1'b0, '0),
            row(IN_CHAR, CH_STAR,   1'b0, '0),
            row(IN_CHAR, CH_NL,     1'b0, '0),
            row(IN_CHAR, CH_STAR,   1'b0, '0),
            row(IN_CHAR, CH_STAR,   1'b0, '0),
            row(IN_CHAR, CH_SLASH,  1'b0, '0),
            row(IN_CHAR, CH_DOLLAR, 1'b0, '0),
            row(IN_EOF,  8'hFF,     1'b0, '0)
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            b.kind      = dir_rows[i].kind;
            b.char_code = dir_rows[i].ch;
            offer(b);
            scan_beat(b);
            if (dir_rows[i].typed) token_q.push_back(dir_rows[i].want);
            else foreach (step_toks[j]) token_q.push_back(step_toks[j]);
            idle(pick_gap(tx_calm));
        end
        drain_wait();

        src_q.delete();
        add_long();
        while (src_q.size() < RAND_ITEMS) add_fragment();
        add_eof();
        foreach (src_q[i]) begin
            feed(src_q[i], pick_gap(tx_calm));
            if ($urandom_range(0, 149) == 0) drain_wait();
        end
        drain_wait();

        src_q.delete();
        add_text("while");
        add_ch(CH_NL);
        repeat (40) add_fragment();
        add_eof();
        foreach (src_q[i]) feed(src_q[i], pick_gap(tx_calm));

        s_valid <= 1'b0;
        do @(posedge aclk); while (token_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (bad_beats == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
